FILE: design/tcpst_pkg.sv
package tcpst_pkg;

  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;
  localparam logic [7:0] FLAGS_PSH_ACK = FLAG_PSH | FLAG_ACK;
  localparam logic [7:0] FLAGS_FIN_ACK = FLAG_FIN | FLAG_ACK;

  localparam logic [1:0] ACT_RECEIVE = 2'd0;
  localparam logic [1:0] ACT_OPEN    = 2'd1;
  localparam logic [1:0] ACT_SEND    = 2'd2;
  localparam logic [1:0] ACT_CLOSE   = 2'd3;

  localparam logic [1:0] LOC_STOPPED   = 2'd0;
  localparam logic [1:0] LOC_ACKWAIT   = 2'd1;
  localparam logic [1:0] LOC_TRANSFER  = 2'd2;
  localparam logic [1:0] LOC_FINISHING = 2'd3;

  localparam logic [1:0] PEER_STOPPED   = 2'd0;
  localparam logic [1:0] PEER_TRANSFER  = 2'd1;
  localparam logic [1:0] PEER_FINISHING = 2'd2;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_ACK    = 3'd1;
  localparam logic [2:0] KIND_PSHACK = 3'd2;
  localparam logic [2:0] KIND_SYNACK = 3'd3;
  localparam logic [2:0] KIND_FINACK = 3'd4;

  localparam logic [15:0] MAX_SEGMENT_RESET = 16'd1450;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] seg_size;
    logic [5:0]  header_bytes;
    logic [15:0] bytes_present;
    logic [15:0] send_length;
  } in_t;

  typedef struct packed {
    logic [2:0]  send_kind;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic        payload_accepted;
    logic [15:0] payload_length;
    logic [15:0] taken_length;
    logic [1:0]  local_now;
    logic [1:0]  peer_now;
  } out_t;

  typedef struct packed {
    logic [1:0]  local_mode;
    logic [1:0]  peer_mode;
    logic [31:0] send_sequence;
    logic [31:0] recv_acknowledge;
    logic [31:0] expected_acknowledge;
    logic        push_sent;
    logic        peer_push_seen;
  } state_t;

endpackage

FILE: design/tcpst_event.sv
module tcpst_event (
  input  tcpst_pkg::state_t cur_state,
  input  tcpst_pkg::in_t    item,
  input  logic [15:0]       max_segment,
  output tcpst_pkg::state_t new_state,
  output tcpst_pkg::out_t   result
);

  logic [15:0] pay;
  logic [15:0] cap;
  logic [15:0] chunk;
  logic        nums_match;

  assign pay        = item.seg_size - {10'd0, item.header_bytes};
  assign cap        = (max_segment == 16'd0) ? 16'd1 : max_segment;
  assign chunk      = (item.send_length > cap) ? cap : item.send_length;
  assign nums_match = (cur_state.expected_acknowledge == item.seg_ack) &&
                      (cur_state.recv_acknowledge == item.seg_seq);

  always_comb begin
    new_state = cur_state;
    result    = '0;
    case (item.action)
      tcpst_pkg::ACT_RECEIVE: begin
        if (item.seg_flags == tcpst_pkg::FLAG_ACK) begin
          if (cur_state.local_mode == tcpst_pkg::LOC_ACKWAIT && nums_match) begin
            new_state.send_sequence        = cur_state.expected_acknowledge;
            new_state.expected_acknowledge = 32'd0;
            new_state.local_mode           = tcpst_pkg::LOC_TRANSFER;
          end
        end else if (item.seg_flags == tcpst_pkg::FLAGS_PSH_ACK) begin
          if (cur_state.local_mode == tcpst_pkg::LOC_TRANSFER) begin
            new_state.peer_push_seen = 1'b1;
            if (cur_state.send_sequence == item.seg_ack &&
                cur_state.recv_acknowledge == item.seg_seq &&
                {10'd0, item.header_bytes} <= item.seg_size &&
                item.bytes_present >= pay) begin
              new_state.recv_acknowledge = cur_state.recv_acknowledge + {16'd0, pay};
              result.payload_accepted    = 1'b1;
              result.payload_length      = pay;
              result.send_kind           = tcpst_pkg::KIND_ACK;
              result.out_seq             = cur_state.send_sequence;
              result.out_ack             = new_state.recv_acknowledge;
            end
          end
        end else if (item.seg_flags == tcpst_pkg::FLAGS_FIN_ACK) begin
          new_state.recv_acknowledge = cur_state.recv_acknowledge + 32'd1;
          if (nums_match) begin
            new_state.send_sequence        = cur_state.expected_acknowledge;
            new_state.expected_acknowledge = 32'd0;
            if (cur_state.peer_mode != tcpst_pkg::PEER_STOPPED) begin
              result.send_kind = tcpst_pkg::KIND_ACK;
            end
          end else begin
            result.send_kind = tcpst_pkg::KIND_ACK;
          end
          if (result.send_kind == tcpst_pkg::KIND_ACK) begin
            result.out_seq = new_state.send_sequence;
            result.out_ack = new_state.recv_acknowledge;
          end
          new_state.peer_mode  = tcpst_pkg::PEER_STOPPED;
          new_state.local_mode = tcpst_pkg::LOC_STOPPED;
        end
      end
      tcpst_pkg::ACT_OPEN: begin
        if ((item.seg_flags & tcpst_pkg::FLAG_SYN) != 8'd0) begin
          new_state.local_mode           = tcpst_pkg::LOC_ACKWAIT;
          new_state.peer_mode            = tcpst_pkg::PEER_TRANSFER;
          new_state.recv_acknowledge     = item.seg_seq + 32'd1;
          new_state.send_sequence        = 32'd0;
          new_state.expected_acknowledge = 32'd1;
          new_state.push_sent            = 1'b0;
          new_state.peer_push_seen       = 1'b0;
          result.send_kind               = tcpst_pkg::KIND_SYNACK;
          result.out_seq                 = 32'd0;
          result.out_ack                 = new_state.recv_acknowledge;
        end
      end
      tcpst_pkg::ACT_SEND: begin
        if (cur_state.peer_mode == tcpst_pkg::PEER_TRANSFER &&
            item.send_length != 16'd0) begin
          result.taken_length            = chunk;
          new_state.expected_acknowledge = cur_state.send_sequence + {16'd0, chunk};
          new_state.send_sequence        = new_state.expected_acknowledge;
          new_state.local_mode           = tcpst_pkg::LOC_ACKWAIT;
          new_state.push_sent            = 1'b1;
          result.send_kind = cur_state.push_sent ? tcpst_pkg::KIND_ACK
                                                 : tcpst_pkg::KIND_PSHACK;
          result.out_seq   = cur_state.send_sequence;
          result.out_ack   = cur_state.recv_acknowledge;
        end else if (cur_state.peer_mode == tcpst_pkg::PEER_FINISHING) begin
          new_state.peer_mode = tcpst_pkg::PEER_STOPPED;
        end
      end
      default: begin
        if (cur_state.local_mode != tcpst_pkg::LOC_STOPPED) begin
          new_state.local_mode = tcpst_pkg::LOC_FINISHING;
        end
        if (cur_state.peer_mode != tcpst_pkg::PEER_STOPPED) begin
          new_state.peer_mode            = tcpst_pkg::PEER_FINISHING;
          new_state.expected_acknowledge = cur_state.send_sequence + 32'd1;
          result.send_kind               = tcpst_pkg::KIND_FINACK;
          result.out_seq                 = cur_state.send_sequence;
          result.out_ack                 = cur_state.recv_acknowledge;
        end
      end
    endcase
    result.local_now = new_state.local_mode;
    result.peer_now  = new_state.peer_mode;
  end

endmodule

FILE: design/tcp_segment_state_tracker.sv
// Tracks one simplified TCP connection and gives one result per event. An event is
// taken in every cycle in which in_stall is low; its result is registered in the
// result or skid register and the state is updated at the same edge, so the next
// event sees it at once. The rate of one event per clock while in_stall is low is
// set by the single state register. A two-entry output stage (result register plus
// skid register) absorbs a stalled receiver; in_stall rises only when both entries
// are full. The user writes the maximum segment size through cfg_ only while no
// events are in flight, not enforced by the block; cfg_ready is always high.
module tcp_segment_state_tracker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcpst_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tcpst_pkg::out_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);

  tcpst_pkg::state_t state_r;
  tcpst_pkg::state_t state_nxt;
  tcpst_pkg::state_t state_calc;
  tcpst_pkg::out_t   result;
  tcpst_pkg::out_t   out_data_r;
  tcpst_pkg::out_t   out_data_nxt;
  tcpst_pkg::out_t   skid_data_r;
  tcpst_pkg::out_t   skid_data_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              skid_valid_r;
  logic              skid_valid_nxt;
  logic [15:0]       max_segment_r;
  logic              in_xfer;
  logic              out_free;

  tcpst_event u_event (
    .cur_state   (state_r),
    .item        (in_data),
    .max_segment (max_segment_r),
    .new_state   (state_calc),
    .result      (result)
  );

  assign in_stall  = skid_valid_r;
  assign in_xfer   = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = in_xfer ? state_calc : state_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_xfer;
        out_data_nxt  = result;
      end
    end else if (in_xfer) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= '0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
      max_segment_r <= tcpst_pkg::MAX_SEGMENT_RESET;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_segment_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while result register empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("transfer during output stall was not kept in skid register");

  a_fin_stops_local: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_data.action == tcpst_pkg::ACT_RECEIVE &&
     in_data.seg_flags == tcpst_pkg::FLAGS_FIN_ACK)
    |=> (state_r.local_mode == tcpst_pkg::LOC_STOPPED &&
         state_r.peer_mode == tcpst_pkg::PEER_STOPPED))
    else $error("FIN-ACK did not stop the connection");
`endif

endmodule
